// ----- rtl/core/bie_pkg.sv -----
// package for the beta instruction executor: opcodes, alu function codes,
// field widths and the control/status structs between controller and datapath
// no dependencies
package bie_pkg;

    localparam int PROG_DEPTH = 256;
    localparam int MEM_DEPTH  = 256;
    localparam int REG_COUNT  = 32;
    localparam int PC_W   = $clog2(PROG_DEPTH);
    localparam int MA_W   = $clog2(MEM_DEPTH);
    localparam int RI_W   = $clog2(REG_COUNT);
    localparam int MCLR_W = MA_W + 1;

    localparam logic [5:0] OP_LD  = 6'd24;
    localparam logic [5:0] OP_ST  = 6'd25;
    localparam logic [5:0] OP_JMP = 6'd27;
    localparam logic [5:0] OP_BEQ = 6'd29;
    localparam logic [5:0] OP_BNE = 6'd30;
    localparam logic [5:0] OP_LDR = 6'd31;

    localparam logic [3:0] FN_ADD = 4'd0;
    localparam logic [3:0] FN_SUB = 4'd1;
    localparam logic [3:0] FN_MUL = 4'd2;
    localparam logic [3:0] FN_DIV = 4'd3;
    localparam logic [3:0] FN_EQ  = 4'd4;
    localparam logic [3:0] FN_LT  = 4'd5;
    localparam logic [3:0] FN_LE  = 4'd6;
    localparam logic [3:0] FN_AND = 4'd8;
    localparam logic [3:0] FN_OR  = 4'd9;
    localparam logic [3:0] FN_XOR = 4'd10;
    localparam logic [3:0] FN_SHL = 4'd12;
    localparam logic [3:0] FN_SHR = 4'd13;
    localparam logic [3:0] FN_SRA = 4'd14;

    // instruction class decided by the controller
    localparam logic [2:0] K_ILL = 3'd0;
    localparam logic [2:0] K_ALU = 3'd1;
    localparam logic [2:0] K_DIV = 3'd2;
    localparam logic [2:0] K_LD  = 3'd3;
    localparam logic [2:0] K_ST  = 3'd4;
    localparam logic [2:0] K_BR  = 3'd5;
    localparam logic [2:0] K_LDR = 3'd6;

    typedef struct packed {
        logic       latch;     // capture instruction word
        logic       operands;  // register read and operand registers
        logic       exec;      // alu / address step
        logic       div_start;
        logic       div_step;
        logic       mem_rd;
        logic       commit;    // write back and load result register
        logic       clr_step;  // memory and register clearing pass
    } bie_cmd_t;

    typedef struct packed {
        logic [5:0] opcode;
        logic       div_done;
        logic       clr_done;
    } bie_stat_t;

    function automatic logic [2:0] op_kind(input logic [5:0] op);
        logic [2:0] k;
        k = K_ILL;
        if (op >= 6'd32) begin
            case (op[3:0])
                FN_ADD, FN_SUB, FN_MUL, FN_EQ, FN_LT, FN_LE, FN_AND, FN_OR,
                FN_XOR, FN_SHL, FN_SHR, FN_SRA: k = K_ALU;
                FN_DIV: k = K_DIV;
                default: k = K_ILL;
            endcase
        end else begin
            case (op)
                OP_LD: k = K_LD;
                OP_ST: k = K_ST;
                OP_JMP, OP_BEQ, OP_BNE: k = K_BR;
                OP_LDR: k = K_LDR;
                default: k = K_ILL;
            endcase
        end
        return k;
    endfunction

endpackage

// ----- rtl/core/bie_ctrl.sv -----
// controller state machine of the beta instruction executor
// depends on bie_pkg
module bie_ctrl import bie_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  bie_stat_t stat,
    output bie_cmd_t  cmd
);
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_OPND = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_MEM  = 3'd5;
    localparam logic [2:0] S_WB   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       mval_reg, mval_next;
    logic [2:0] kind;

    assign kind     = op_kind(stat.opcode);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mval_reg;

    always_comb begin
        state_next = state_reg;
        mval_next  = mval_reg;
        cmd        = '0;
        if (m_tvalid && m_tready) mval_next = 1'b0;
        unique case (state_reg)
            S_CLR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_OPND;
                end
            end
            S_OPND: begin
                cmd.operands = 1'b1;
                state_next   = S_EXEC;
            end
            S_EXEC: begin
                if (kind == K_DIV) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end else begin
                    cmd.exec   = 1'b1;
                    state_next = (kind == K_LD || kind == K_LDR) ? S_MEM : S_WB;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) state_next = S_WB;
            end
            S_MEM: begin
                cmd.mem_rd = 1'b1;
                state_next = S_WB;
            end
            S_WB: begin
                if (!mval_reg || m_tready) begin
                    cmd.commit = 1'b1;
                    mval_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mval_reg  <= mval_next;
        end
    end

`ifndef SYNTHESIS
    a_commit_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> state_reg == S_WB) else $error("commit outside write-back");
    a_out_after_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid) else $error("result not presented");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready) else $error("ready while busy");
`endif
endmodule

// ----- rtl/core/bie_dpath.sv -----
// datapath: pc, register bank, data memory, alu, serial divider, result register
// depends on bie_pkg
module bie_dpath import bie_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] s_instr,
    input  bie_cmd_t    cmd,
    output bie_stat_t   stat,
    output logic [63:0] m_data
);
    logic [31:0]      ir_reg;
    logic [PC_W-1:0]  pc_reg;
    logic [31:0]      rf [REG_COUNT];
    logic [31:0]      dmem [MEM_DEPTH];
    logic [31:0]      va_reg, vb_reg, vc_reg, res_reg;
    logic [MA_W-1:0]  addr_reg;
    logic [PC_W-1:0]  npc_reg;
    logic [MCLR_W-1:0] clr_reg;
    logic [31:0]      quo_reg, rem_reg;
    logic [5:0]       dcnt_reg;
    logic             dz_reg;
    logic [MCLR_W-1:0] clr_next;

    logic [5:0]      op;
    logic [RI_W-1:0] rc, ra, rb;
    logic [15:0]     lit;
    logic [2:0]      kind;
    logic [31:0]     opb;
    logic [4:0]      sh;
    logic [31:0]     alu_y;
    logic [PC_W-1:0] pc1;
    logic [32:0]     rem_try;

    assign op   = ir_reg[31:26];
    assign rc   = ir_reg[25:21];
    assign ra   = ir_reg[20:16];
    assign rb   = ir_reg[15:11];
    assign lit  = ir_reg[15:0];
    assign kind = op_kind(op);
    assign opb  = op[4] ? {16'd0, lit} : vb_reg;
    assign sh   = opb[4:0];
    assign pc1  = pc_reg + 1'b1;

    assign stat.opcode   = op;
    assign stat.div_done = (dcnt_reg == 6'd0);
    assign stat.clr_done = clr_reg[MA_W];

    always_comb begin
        case (op[3:0])
            FN_ADD: alu_y = va_reg + opb;
            FN_SUB: alu_y = va_reg - opb;
            FN_MUL: alu_y = va_reg * opb;
            FN_EQ:  alu_y = {31'd0, va_reg == opb};
            FN_LT:  alu_y = {31'd0, va_reg < opb};
            FN_LE:  alu_y = {31'd0, va_reg <= opb};
            FN_AND: alu_y = va_reg & opb;
            FN_OR:  alu_y = va_reg | opb;
            FN_XOR: alu_y = va_reg ^ opb;
            FN_SHL: alu_y = va_reg << sh;
            FN_SHR: alu_y = va_reg >> sh;
            FN_SRA: alu_y = $unsigned($signed(va_reg) >>> sh);
            default: alu_y = '0;
        endcase
    end

    // divisor is the register or the literal, as for the other alu ops
    assign rem_try = {rem_reg, quo_reg[31]} - {1'b0, opb};
    assign clr_next = clr_reg + 1'b1;

    // register bank and operand fetch
    always_ff @(posedge aclk) begin
        if (cmd.latch) ir_reg <= s_instr;
        if (cmd.operands) begin
            va_reg <= rf[ra];
            vb_reg <= rf[rb];
            vc_reg <= rf[rc];
        end
        if (cmd.clr_step) rf[clr_reg[RI_W-1:0]] <= '0;
        else if (cmd.commit && kind != K_ILL && kind != K_ST) rf[rc] <= res_reg;
    end

    // data memory
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) dmem[clr_reg[MA_W-1:0]] <= '0;
        else if (cmd.commit && kind == K_ST) dmem[addr_reg] <= vc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) clr_reg <= '0;
        else if (cmd.clr_step && !clr_reg[MA_W]) clr_reg <= clr_next;
    end

    // execute step, divider steps and memory read
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            dz_reg  <= 1'b0;
            npc_reg <= pc1;
            res_reg <= '0;
            addr_reg <= '0;
            case (kind)
                K_ALU: res_reg <= alu_y;
                K_LD, K_ST: begin
                    addr_reg <= va_reg[MA_W-1:0] + lit[MA_W-1:0];
                    res_reg  <= vc_reg;
                end
                K_LDR: addr_reg <= MA_W'(pc1) + lit[MA_W-1:0];
                K_BR: begin
                    res_reg <= 32'(pc1);
                    if (op == OP_JMP)
                        npc_reg <= va_reg[PC_W-1:0] & {{(PC_W-2){1'b1}}, 2'b00};
                    else if ((op == OP_BEQ) == (va_reg == 32'd0))
                        npc_reg <= pc1 + lit[PC_W-1:0];
                end
                default: npc_reg <= pc_reg;
            endcase
        end else if (cmd.div_start) begin
            npc_reg  <= pc1;
            addr_reg <= '0;
            quo_reg  <= va_reg;
            rem_reg  <= '0;
            dcnt_reg <= 6'd32;
            dz_reg   <= (opb == 32'd0);
        end else if (cmd.div_step && dcnt_reg != 6'd0) begin
            dcnt_reg <= dcnt_reg - 6'd1;
            if (!rem_try[32]) begin
                rem_reg <= rem_try[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[30:0], quo_reg[31]};
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end else if (cmd.div_step) begin
            res_reg <= dz_reg ? '1 : quo_reg;
        end else if (cmd.mem_rd) begin
            res_reg <= dmem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) pc_reg <= '0;
        else if (cmd.commit) pc_reg <= npc_reg;
    end

    // result beat: next_pc, is_store, dest_reg, result_value, store_addr, illegal, div_zero
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_data[7:0]   <= 8'(npc_reg);
            m_data[8]     <= (kind == K_ST);
            m_data[13:9]  <= (kind == K_ILL || kind == K_ST) ? 5'd0 : rc;
            m_data[45:14] <= res_reg;
            m_data[53:46] <= (kind == K_ST) ? 8'(addr_reg) : 8'd0;
            m_data[54]    <= (kind == K_ILL);
            m_data[55]    <= (kind == K_DIV) && dz_reg;
            m_data[63:56] <= '0;
        end
    end

`ifndef SYNTHESIS
    a_div_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> dcnt_reg == 6'd32) else $error("divider not loaded");
    a_clr_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.clr_done |=> stat.clr_done) else $error("clear pass restarted");
    a_pc_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.commit |=> $stable(pc_reg)) else $error("pc moved without commit");
`endif
endmodule

// ----- rtl/core/beta_instruction_executor.sv -----
// beta instruction executor: one instruction word in, one result beat out
// throughput: one instruction at a time, next beat taken after the result is loaded
// reset: synchronous active-low aresetn clears pc and control, then a clearing pass
// zeroes data memory and registers before the first beat is taken
// depends on bie_pkg, bie_ctrl, bie_dpath
module beta_instruction_executor import bie_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // instr_word
    output logic        m_tvalid,
    input  logic        m_tready,
    // next_pc[7:0], is_store[8], dest_reg[13:9], result_value[45:14],
    // store_addr[53:46], illegal_op[54], div_zero[55], zero fill
    output logic [63:0] m_tdata
);
    bie_cmd_t  cmd;
    bie_stat_t stat;

    // sequencing of fetch, execute, divide and write back
    bie_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
        .stat, .cmd
    );

    // state and arithmetic
    bie_dpath u_dpath (
        .aclk, .aresetn, .s_instr(s_tdata), .cmd, .stat, .m_data(m_tdata)
    );
endmodule
